[sv/prlf_pkg.sv]
// ----------------------------------------------------------------------------
// prlf_pkg
// Shared types and constants of the LRU/FIFO page replacement block.
// ----------------------------------------------------------------------------
package prlf_pkg;

  // Fixed field widths
  localparam int unsigned ADDR_W      = 28;
  localparam int unsigned FRAME_OUT_W = 4;
  localparam int unsigned EVPAGE_W    = 10;
  localparam int unsigned COUNT_W     = 32;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 5;
  localparam int unsigned SHIFT_W     = 5;
  localparam int unsigned PCS_W       = 4;
  localparam int unsigned FIU_W       = 5;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POLICY           = 2'd0,
    CFG_PAGE_SHIFT       = 2'd1,
    CFG_PAGE_COUNT_SHIFT = 2'd2,
    CFG_FRAMES_IN_USE    = 2'd3
  } cfg_idx_e;

  // Replacement policy
  typedef enum logic {
    POLICY_LRU  = 1'b0,
    POLICY_FIFO = 1'b1
  } policy_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_CLEAR = 3'd0,
    ST_IDLE  = 3'd1,
    ST_LOOK  = 3'd2,
    ST_SCAN  = 3'd3,
    ST_EVICT = 3'd4,
    ST_PLACE = 3'd5,
    ST_RESP  = 3'd6
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic clr_step;
    logic accept;
    logic res_oor;
    logic res_hit;
    logic scan_step;
    logic evict;
    logic place;
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic clr_last;
    logic oor;
    logic map_hit;
    logic scan_done;
  } dp_status_t;

endpackage

[sv/prlf_ram.sv]
// ----------------------------------------------------------------------------
// prlf_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module prlf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/prlf_ctrl.sv]
// ----------------------------------------------------------------------------
// prlf_ctrl
// Sequencer: clearing pass, lookup, victim scan, evict and place steps.
// ----------------------------------------------------------------------------
module prlf_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  output logic                  done_o,
  input  prlf_pkg::dp_status_t  status_i,
  output prlf_pkg::dp_cmd_t     cmd_o
);

  prlf_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= prlf_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      prlf_pkg::ST_CLEAR: begin
        if (status_i.clr_last) state_d = prlf_pkg::ST_IDLE;
      end
      prlf_pkg::ST_IDLE, prlf_pkg::ST_RESP: begin
        if (start_i) state_d = prlf_pkg::ST_LOOK;
        else         state_d = prlf_pkg::ST_IDLE;
      end
      prlf_pkg::ST_LOOK: begin
        if (status_i.oor || status_i.map_hit) state_d = prlf_pkg::ST_RESP;
        else                                  state_d = prlf_pkg::ST_SCAN;
      end
      prlf_pkg::ST_SCAN: begin
        if (status_i.scan_done) state_d = prlf_pkg::ST_EVICT;
      end
      prlf_pkg::ST_EVICT: state_d = prlf_pkg::ST_PLACE;
      prlf_pkg::ST_PLACE: state_d = prlf_pkg::ST_RESP;
      default:            state_d = prlf_pkg::ST_IDLE;
    endcase
  end

  // Outputs and datapath commands
  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    done_o = 1'b0;
    unique case (state_q)
      prlf_pkg::ST_CLEAR: cmd_o.clr_step = 1'b1;
      prlf_pkg::ST_IDLE: begin
        busy_o       = 1'b0;
        cmd_o.accept = start_i;
      end
      prlf_pkg::ST_RESP: begin
        busy_o       = 1'b0;
        done_o       = 1'b1;
        cmd_o.accept = start_i;
      end
      prlf_pkg::ST_LOOK: begin
        cmd_o.res_oor = status_i.oor;
        cmd_o.res_hit = !status_i.oor && status_i.map_hit;
      end
      prlf_pkg::ST_SCAN:  cmd_o.scan_step = 1'b1;
      prlf_pkg::ST_EVICT: cmd_o.evict     = 1'b1;
      prlf_pkg::ST_PLACE: cmd_o.place     = 1'b1;
      default: begin
        busy_o = 1'b1;
      end
    endcase
  end

endmodule

[sv/prlf_dp.sv]
// ----------------------------------------------------------------------------
// prlf_dp
// Datapath: config registers, page map memory, frame tables, victim scan,
// counters and result registers.
// ----------------------------------------------------------------------------
module prlf_dp #(
  parameter int unsigned MAX_FRAMES = 16,
  parameter int unsigned MAX_PAGES  = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [prlf_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [prlf_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic [prlf_pkg::ADDR_W-1:0]        address_i,
  input  prlf_pkg::dp_cmd_t                  cmd_i,
  output prlf_pkg::dp_status_t               status_o,
  output logic                               hit_o,
  output logic [prlf_pkg::FRAME_OUT_W-1:0]   frame_o,
  output logic                               evicted_valid_o,
  output logic [prlf_pkg::EVPAGE_W-1:0]      evicted_page_o,
  output logic                               out_of_range_o,
  output logic [prlf_pkg::COUNT_W-1:0]       misses_o
);

  localparam int unsigned AW   = prlf_pkg::ADDR_W;
  localparam int unsigned CW   = prlf_pkg::COUNT_W;
  localparam int unsigned FOW  = prlf_pkg::FRAME_OUT_W;
  localparam int unsigned EW   = prlf_pkg::EVPAGE_W;
  localparam int unsigned FW   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int unsigned PW   = $clog2(MAX_PAGES);
  localparam int unsigned NFB  = $clog2(MAX_FRAMES + 1);
  localparam int unsigned NF_W = (NFB > prlf_pkg::FIU_W) ? NFB : prlf_pkg::FIU_W;

  // Configuration registers
  prlf_pkg::policy_e               policy_q;
  logic [prlf_pkg::SHIFT_W-1:0]    page_shift_q;
  logic [prlf_pkg::PCS_W-1:0]      pcs_q;
  logic [prlf_pkg::FIU_W-1:0]      fiu_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q     <= prlf_pkg::POLICY_LRU;
      page_shift_q <= prlf_pkg::SHIFT_W'(12);
      pcs_q        <= prlf_pkg::PCS_W'(10);
      fiu_q        <= prlf_pkg::FIU_W'(4);
    end else if (cfg_we_i) begin
      unique case (prlf_pkg::cfg_idx_e'(cfg_idx_i))
        prlf_pkg::CFG_POLICY:           policy_q     <= prlf_pkg::policy_e'(cfg_data_i[0]);
        prlf_pkg::CFG_PAGE_SHIFT:       page_shift_q <= cfg_data_i[prlf_pkg::SHIFT_W-1:0];
        prlf_pkg::CFG_PAGE_COUNT_SHIFT: pcs_q        <= cfg_data_i[prlf_pkg::PCS_W-1:0];
        prlf_pkg::CFG_FRAMES_IN_USE:    fiu_q        <= cfg_data_i[prlf_pkg::FIU_W-1:0];
        default: ;
      endcase
    end
  end

  // Page number and range check
  logic [AW-1:0] page_w, limit_w;
  logic          oor_d;

  assign page_w = address_i >> page_shift_q;

  always_comb begin
    limit_w = AW'(1) << pcs_q;
    if (limit_w > AW'(MAX_PAGES)) limit_w = AW'(MAX_PAGES);
  end

  assign oor_d = (page_w >= limit_w);

  // Active frame count: zero acts as one, capped at the frame table size
  logic [NF_W-1:0] nf;
  logic [FW-1:0]   last_idx;

  always_comb begin
    nf = NF_W'(fiu_q);
    if (nf == '0) nf = NF_W'(1);
    if (nf > NF_W'(MAX_FRAMES)) nf = NF_W'(MAX_FRAMES);
  end

  assign last_idx = FW'(nf - NF_W'(1));

  // Item registers and counters
  logic [PW-1:0] page_q;
  logic          oor_q;
  logic [PW-1:0] clr_q;
  logic [FW-1:0] scan_k_q;
  logic [CW-1:0] clock_q, miss_q;

  // Frame tables
  logic [MAX_FRAMES-1:0] owner_v_q;
  logic [PW-1:0]         owner_pg_q [MAX_FRAMES];
  logic [CW-1:0]         stamp_q    [MAX_FRAMES];

  // Victim candidate
  logic [FW-1:0] vic_q;
  logic          vic_own_v_q;
  logic [PW-1:0] vic_page_q;
  logic [CW-1:0] best_stamp_q;

  // Result registers
  logic          res_hit_q, res_ev_v_q, res_oor_q;
  logic [FW-1:0] res_frame_q;
  logic [PW-1:0] res_ev_page_q;

  // Page map memory: valid bit and frame index
  logic          map_we;
  logic [PW-1:0] map_waddr;
  logic [FW:0]   map_wdata, map_rdata;

  always_comb begin
    map_we    = 1'b0;
    map_waddr = clr_q;
    map_wdata = '0;
    if (cmd_i.clr_step) begin
      map_we = 1'b1;
    end else if (cmd_i.evict) begin
      map_we    = vic_own_v_q;
      map_waddr = vic_page_q;
    end else if (cmd_i.place) begin
      map_we    = 1'b1;
      map_waddr = page_q;
      map_wdata = {1'b1, vic_q};
    end
  end

  prlf_ram #(
    .WIDTH (FW + 1),
    .DEPTH (MAX_PAGES)
  ) u_page_map (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .re_i    (cmd_i.accept),
    .raddr_i (PW'(page_w)),
    .rdata_o (map_rdata)
  );

  // Scan step: first empty frame wins, else the smallest stamp, lowest index
  logic          empty_k, better_k;
  logic [FW-1:0] hit_frame;

  assign empty_k   = !owner_v_q[scan_k_q];
  assign better_k  = (scan_k_q == '0) || (stamp_q[scan_k_q] < best_stamp_q);
  assign hit_frame = map_rdata[FW-1:0];

  assign status_o.clr_last  = (clr_q == PW'(MAX_PAGES - 1));
  assign status_o.oor       = oor_q;
  assign status_o.map_hit   = map_rdata[FW];
  assign status_o.scan_done = empty_k || (scan_k_q == last_idx);

  // Saturating counter next values
  logic [CW-1:0] clock_inc, miss_inc;
  assign clock_inc = (clock_q == '1) ? clock_q : clock_q + 1'b1;
  assign miss_inc  = (miss_q == '1) ? miss_q : miss_q + 1'b1;

  // Control state: sweep counter, access clock, miss total, owner valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= '0;
      clock_q   <= CW'(1);
      miss_q    <= '0;
      owner_v_q <= '0;
    end else begin
      if (cmd_i.clr_step) clr_q <= clr_q + 1'b1;
      if (cmd_i.res_hit) clock_q <= clock_inc;
      if (cmd_i.place) begin
        clock_q          <= clock_inc;
        miss_q           <= miss_inc;
        owner_v_q[vic_q] <= 1'b1;
      end
    end
  end

  // Payload: item, scan, frame tables and results
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      page_q   <= PW'(page_w);
      oor_q    <= oor_d;
      scan_k_q <= '0;
    end
    if (cmd_i.scan_step) begin
      scan_k_q <= scan_k_q + 1'b1;
      if (empty_k) begin
        vic_q       <= scan_k_q;
        vic_own_v_q <= 1'b0;
      end else if (better_k) begin
        vic_q        <= scan_k_q;
        vic_own_v_q  <= 1'b1;
        vic_page_q   <= owner_pg_q[scan_k_q];
        best_stamp_q <= stamp_q[scan_k_q];
      end
    end
    if (cmd_i.res_oor) begin
      res_hit_q     <= 1'b0;
      res_frame_q   <= '0;
      res_ev_v_q    <= 1'b0;
      res_ev_page_q <= '0;
      res_oor_q     <= 1'b1;
    end
    if (cmd_i.res_hit) begin
      if (policy_q == prlf_pkg::POLICY_LRU) stamp_q[hit_frame] <= clock_q;
      res_hit_q     <= 1'b1;
      res_frame_q   <= hit_frame;
      res_ev_v_q    <= 1'b0;
      res_ev_page_q <= '0;
      res_oor_q     <= 1'b0;
    end
    if (cmd_i.place) begin
      owner_pg_q[vic_q] <= page_q;
      stamp_q[vic_q]    <= clock_q;
      res_hit_q         <= 1'b0;
      res_frame_q       <= vic_q;
      res_ev_v_q        <= vic_own_v_q;
      res_ev_page_q     <= vic_own_v_q ? vic_page_q : '0;
      res_oor_q         <= 1'b0;
    end
  end

  // Drive result ports
  assign hit_o           = res_hit_q;
  assign frame_o         = FOW'(res_frame_q);
  assign evicted_valid_o = res_ev_v_q;
  assign evicted_page_o  = EW'(res_ev_page_q);
  assign out_of_range_o  = res_oor_q;
  assign misses_o        = miss_q;

endmodule

[sv/page_replacement_lru_fifo.sv]
// ----------------------------------------------------------------------------
// page_replacement_lru_fifo
// Hit or out-of-range item: accept, LOOK, then done_o strobes in RESP; the
// next item may start in the done cycle. Miss: accept, LOOK, SCAN over S
// frames (1 to active frames, stops at the first empty frame), EVICT, PLACE,
// RESP; the stamp scan makes one compare per cycle. After reset busy stays
// high while the page map is cleared one entry a cycle; configuration writes
// are taken meanwhile.
// ----------------------------------------------------------------------------
module page_replacement_lru_fifo #(
  parameter int unsigned MAX_FRAMES = 16,
  parameter int unsigned MAX_PAGES  = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [prlf_pkg::ADDR_W-1:0]        address_i,
  input  logic                               cfg_we_i,
  input  logic [prlf_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [prlf_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output logic                               done_o,
  output logic                               hit_o,
  output logic [prlf_pkg::FRAME_OUT_W-1:0]   frame_o,
  output logic                               evicted_valid_o,
  output logic [prlf_pkg::EVPAGE_W-1:0]      evicted_page_o,
  output logic                               out_of_range_o,
  output logic [prlf_pkg::COUNT_W-1:0]       misses_o
);

  prlf_pkg::dp_cmd_t    cmd;
  prlf_pkg::dp_status_t status;

  // Sequencer
  prlf_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .busy_o   (busy),
    .done_o   (done_o),
    .status_i (status),
    .cmd_o    (cmd)
  );

  // Datapath
  prlf_dp #(
    .MAX_FRAMES (MAX_FRAMES),
    .MAX_PAGES  (MAX_PAGES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .address_i       (address_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .hit_o           (hit_o),
    .frame_o         (frame_o),
    .evicted_valid_o (evicted_valid_o),
    .evicted_page_o  (evicted_page_o),
    .out_of_range_o  (out_of_range_o),
    .misses_o        (misses_o)
  );

  // Result strobe is never held high in back-to-back cycles
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("done_o held for more than one cycle");

  // An accepted item keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting an item");

  // Out-of-range result carries no hit and no eviction
  a_oor_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && out_of_range_o) |-> (!hit_o && !evicted_valid_o))
    else $error("out-of-range result with hit or eviction");

  // A hit never evicts
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && hit_o) |-> !evicted_valid_o)
    else $error("hit result reports an eviction");

  // A miss result shows a nonzero miss total
  a_miss_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !hit_o && !out_of_range_o) |-> (misses_o != '0))
    else $error("miss result with zero miss total");

  // Hits and out-of-range items leave the miss total alone
  a_miss_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (hit_o || out_of_range_o)) |-> $stable(misses_o))
    else $error("miss total changed on a hit or out-of-range item");

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Checks the LRU/FIFO page replacement block. A short table of directed items
// and register writes runs first, then randomized phases of page references
// drawn from small working sets under varied settings. Every result is checked
// field by field against a table value or an in-bench residency predictor.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_FRAMES  = 16;
  localparam int unsigned MAX_PAGES   = 1024;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASE_ITEMS = 90;

  typedef struct packed {
    logic                             hit;
    logic [prlf_pkg::FRAME_OUT_W-1:0] frame;
    logic                             ev_valid;
    logic [prlf_pkg::EVPAGE_W-1:0]    ev_page;
    logic                             oor;
    logic [prlf_pkg::COUNT_W-1:0]     misses;
  } access_result_t;

  typedef struct {
    bit                              is_cfg;
    prlf_pkg::cfg_idx_e              idx;
    logic [prlf_pkg::CFG_DATA_W-1:0] data;
    logic [prlf_pkg::ADDR_W-1:0]     addr;
    bit                              fixed;
    access_result_t                  res;
  } stim_row_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni;
  logic                             start;
  logic                             busy;
  logic [prlf_pkg::ADDR_W-1:0]      address_i;
  logic                             cfg_we_i;
  logic [prlf_pkg::CFG_IDX_W-1:0]   cfg_idx_i;
  logic [prlf_pkg::CFG_DATA_W-1:0]  cfg_data_i;
  logic                             done_o;
  logic                             hit_o;
  logic [prlf_pkg::FRAME_OUT_W-1:0] frame_o;
  logic                             evicted_valid_o;
  logic [prlf_pkg::EVPAGE_W-1:0]    evicted_page_o;
  logic                             out_of_range_o;
  logic [prlf_pkg::COUNT_W-1:0]     misses_o;

  // Predictor state: settings and residency tables
  prlf_pkg::policy_e               pol_mirror    = prlf_pkg::POLICY_LRU;
  logic [prlf_pkg::SHIFT_W-1:0]    shift_mirror  = 5'd12;
  logic [prlf_pkg::PCS_W-1:0]      count_mirror  = 4'd10;
  logic [prlf_pkg::FIU_W-1:0]      frames_mirror = 5'd4;
  bit                              page_resident [MAX_PAGES] = '{default: 1'b0};
  int unsigned                     page_frame    [MAX_PAGES] = '{default: 0};
  bit                              frame_used    [MAX_FRAMES] = '{default: 1'b0};
  int unsigned                     frame_page    [MAX_FRAMES] = '{default: 0};
  logic [prlf_pkg::COUNT_W-1:0]    frame_stamp   [MAX_FRAMES] = '{default: '0};
  logic [prlf_pkg::COUNT_W-1:0]    access_clock  = 32'd1;
  logic [prlf_pkg::COUNT_W-1:0]    miss_total    = '0;

  access_result_t        expected_results [$];
  stim_row_t             plan [$];
  int unsigned           fail_count = 0;
  int                    burst_left = 0;
  int unsigned           cycle_count;

  page_replacement_lru_fifo #(
    .MAX_FRAMES(MAX_FRAMES),
    .MAX_PAGES (MAX_PAGES)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .address_i      (address_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .done_o         (done_o),
    .hit_o          (hit_o),
    .frame_o        (frame_o),
    .evicted_valid_o(evicted_valid_o),
    .evicted_page_o (evicted_page_o),
    .out_of_range_o (out_of_range_o),
    .misses_o       (misses_o)
  );

  always #5 clk_i = ~clk_i;

  // Work out the result of one reference and advance the residency tables
  function automatic access_result_t predict_access(
    input logic [prlf_pkg::ADDR_W-1:0] addr
  );
    access_result_t    r;
    longint unsigned   page_no;
    int unsigned       page_limit;
    int unsigned       n_act;
    int unsigned       victim;
    r = '0;
    page_no = {36'd0, addr} >> shift_mirror;
    page_limit = (count_mirror >= 4'd10) ? MAX_PAGES : (1 << count_mirror);
    if (page_no >= page_limit) begin
      r.oor = 1'b1;
      r.misses = miss_total;
      return r;
    end
    if (page_resident[page_no]) begin
      r.hit = 1'b1;
      r.frame = prlf_pkg::FRAME_OUT_W'(page_frame[page_no]);
      if (pol_mirror == prlf_pkg::POLICY_LRU) begin
        frame_stamp[page_frame[page_no]] = access_clock;
      end
    end else begin
      n_act = (frames_mirror == 0) ? 1 :
              (frames_mirror > MAX_FRAMES) ? MAX_FRAMES : frames_mirror;
      // empty frames first, lowest index wins
      victim = n_act;
      for (int k = 0; k < n_act; k++) begin
        if (!frame_used[k] && victim == n_act) victim = k;
      end
      // otherwise oldest stamp, lowest index on ties
      if (victim == n_act) begin
        victim = 0;
        for (int k = 1; k < n_act; k++) begin
          if (frame_stamp[k] < frame_stamp[victim]) victim = k;
        end
      end
      if (miss_total != '1) miss_total++;
      if (frame_used[victim]) begin
        page_resident[frame_page[victim]] = 1'b0;
        r.ev_valid = 1'b1;
        r.ev_page = prlf_pkg::EVPAGE_W'(frame_page[victim]);
      end
      page_resident[page_no] = 1'b1;
      page_frame[page_no] = victim;
      frame_used[victim] = 1'b1;
      frame_page[victim] = int'(page_no);
      frame_stamp[victim] = access_clock;
      r.frame = prlf_pkg::FRAME_OUT_W'(victim);
    end
    if (access_clock != '1) access_clock++;
    r.misses = miss_total;
    return r;
  endfunction

  function automatic access_result_t res_of(input logic hit, input int frame,
                                            input logic evv, input int evp,
                                            input logic oor, input int misses);
    access_result_t r;
    r.hit = hit;
    r.frame = prlf_pkg::FRAME_OUT_W'(frame);
    r.ev_valid = evv;
    r.ev_page = prlf_pkg::EVPAGE_W'(evp);
    r.oor = oor;
    r.misses = prlf_pkg::COUNT_W'(misses);
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input prlf_pkg::cfg_idx_e idx,
                                        input logic [prlf_pkg::CFG_DATA_W-1:0] data);
    stim_row_t row;
    row = '{is_cfg: 1'b1, idx: idx, data: data, addr: '0, fixed: 1'b0, res: '0};
    return row;
  endfunction

  function automatic stim_row_t item_row(input logic [prlf_pkg::ADDR_W-1:0] addr);
    stim_row_t row;
    row = '{is_cfg: 1'b0, idx: prlf_pkg::CFG_POLICY, data: '0, addr: addr,
            fixed: 1'b0, res: '0};
    return row;
  endfunction

  function automatic stim_row_t fixed_row(input logic [prlf_pkg::ADDR_W-1:0] addr,
                                          input access_result_t res);
    stim_row_t row;
    row = '{is_cfg: 1'b0, idx: prlf_pkg::CFG_POLICY, data: '0, addr: addr,
            fixed: 1'b1, res: res};
    return row;
  endfunction

  // Burst control: zero keeps start high, otherwise the gap length
  function automatic int next_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    burst_left = $urandom_range(0, 12);
    return ($urandom_range(0, 4) == 0) ? 0 : int'($urandom_range(1, 9));
  endfunction

  // Present one item, hold until taken, record its expected result
  task automatic issue(input logic [prlf_pkg::ADDR_W-1:0] addr, input bit use_fixed,
                       input access_result_t fixed_res, input bit hold);
    access_result_t predicted;
    start <= 1'b1;
    address_i <= addr;
    do @(posedge clk_i); while (busy !== 1'b0);
    predicted = predict_access(addr);
    expected_results.push_back(use_fixed ? fixed_res : predicted);
    if (!hold) start <= 1'b0;
  endtask

  // Write one register; the caller drops the write enable after a batch
  task automatic write_reg(input prlf_pkg::cfg_idx_e idx,
                           input logic [prlf_pkg::CFG_DATA_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      prlf_pkg::CFG_POLICY:           pol_mirror = prlf_pkg::policy_e'(data[0]);
      prlf_pkg::CFG_PAGE_SHIFT:       shift_mirror = data;
      prlf_pkg::CFG_PAGE_COUNT_SHIFT: count_mirror = data[prlf_pkg::PCS_W-1:0];
      prlf_pkg::CFG_FRAMES_IN_USE:    frames_mirror = data;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // Check each result against the oldest expectation
  always @(posedge clk_i) begin
    access_result_t exp_r;
    if (rst_ni === 1'b1 && done_o === 1'b1) begin
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected result at %0t", $realtime);
      end else begin
        exp_r = expected_results.pop_front();
        if (hit_o !== exp_r.hit || frame_o !== exp_r.frame ||
            evicted_valid_o !== exp_r.ev_valid || evicted_page_o !== exp_r.ev_page ||
            out_of_range_o !== exp_r.oor || misses_o !== exp_r.misses) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("mismatch at %0t: exp hit=%0d frame=%0d ev=%0d/%0d oor=%0d misses=%0d",
                     $realtime, exp_r.hit, exp_r.frame, exp_r.ev_valid, exp_r.ev_page,
                     exp_r.oor, exp_r.misses);
            $display("                 got hit=%0d frame=%0d ev=%0d/%0d oor=%0d misses=%0d",
                     hit_o, frame_o, evicted_valid_o, evicted_page_o,
                     out_of_range_o, misses_o);
          end
        end
      end
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int                              gap;
    int unsigned                     page_limit;
    int unsigned                     n_act;
    int unsigned                     sel;
    longint unsigned                 page_no;
    longint unsigned                 off_mask;
    logic [prlf_pkg::ADDR_W-1:0]     addr;
    int unsigned                     pool [$];
    prlf_pkg::policy_e               pol_val;
    logic [prlf_pkg::SHIFT_W-1:0]    shift_val;
    logic [prlf_pkg::PCS_W-1:0]      pcs_val;
    logic [prlf_pkg::FIU_W-1:0]      fiu_val;
    bit                              hold;

    rst_ni     = 1'b0;
    start      = 1'b0;
    address_i  = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = prlf_pkg::CFG_POLICY;
    cfg_data_i = '0;

    // Directed table: reset settings are LRU, 4 KiB pages, 1024 pages, 4 frames
    plan.push_back(fixed_row(28'h000_0000, res_of(0, 0, 0, 0, 0, 1)));
    plan.push_back(fixed_row(28'h000_0FFF, res_of(1, 0, 0, 0, 0, 1)));
    plan.push_back(fixed_row(28'h040_0000, res_of(0, 0, 0, 0, 1, 1)));
    plan.push_back(fixed_row(28'h03F_FFFF, res_of(0, 1, 0, 0, 0, 2)));
    plan.push_back(fixed_row(28'hFFF_FFFF, res_of(0, 0, 0, 0, 1, 2)));
    plan.push_back(fixed_row(28'h000_2000, res_of(0, 2, 0, 0, 0, 3)));
    plan.push_back(fixed_row(28'h000_3000, res_of(0, 3, 0, 0, 0, 4)));
    // all frames full: evict the oldest stamp
    plan.push_back(item_row(28'h000_1000));
    plan.push_back(item_row(28'h03F_F000));
    plan.push_back(item_row(28'h000_5000));
    // FIFO: a hit must not save its frame from eviction
    plan.push_back(cfg_row(prlf_pkg::CFG_POLICY, {4'b1111, prlf_pkg::POLICY_FIFO}));
    plan.push_back(item_row(28'h000_3000));
    plan.push_back(item_row(28'h000_6000));
    // zero frames acts as one; frames above the count still hit
    plan.push_back(cfg_row(prlf_pkg::CFG_FRAMES_IN_USE, 5'd0));
    plan.push_back(item_row(28'h000_7000));
    plan.push_back(item_row(28'h03F_F000));
    plan.push_back(cfg_row(prlf_pkg::CFG_FRAMES_IN_USE, 5'd31));
    plan.push_back(item_row(28'h000_8000));
    // byte pages with a single logical page
    plan.push_back(cfg_row(prlf_pkg::CFG_PAGE_SHIFT, 5'd0));
    plan.push_back(cfg_row(prlf_pkg::CFG_PAGE_COUNT_SHIFT, 5'd0));
    plan.push_back(item_row(28'h000_0000));
    plan.push_back(item_row(28'h000_0001));
    // shift wider than the address, page count saturated
    plan.push_back(cfg_row(prlf_pkg::CFG_PAGE_SHIFT, 5'd31));
    plan.push_back(cfg_row(prlf_pkg::CFG_PAGE_COUNT_SHIFT, 5'd15));
    plan.push_back(item_row(28'hFFF_FFFF));
    plan.push_back(cfg_row(prlf_pkg::CFG_PAGE_SHIFT, 5'd27));
    plan.push_back(cfg_row(prlf_pkg::CFG_PAGE_COUNT_SHIFT, 5'd1));
    plan.push_back(item_row(28'h800_0000));
    plan.push_back(item_row(28'h7FF_FFFF));
    plan.push_back(item_row(28'h000_0000));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Walk the directed table
    for (int i = 0; i < plan.size(); i++) begin
      if (plan[i].is_cfg) begin
        wait_drained();
        write_reg(plan[i].idx, plan[i].data);
        if (i + 1 >= plan.size() || !plan[i + 1].is_cfg) cfg_we_i <= 1'b0;
      end else begin
        gap = (i + 1 < plan.size() && !plan[i + 1].is_cfg) ? next_gap() : -1;
        issue(plan[i].addr, plan[i].fixed, plan[i].res, gap == 0);
        if (gap > 0) repeat (gap) @(posedge clk_i);
      end
    end

    // Random phases, each under its own settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          pol_val = prlf_pkg::POLICY_LRU;
          shift_val = 5'd12; pcs_val = 4'd10; fiu_val = 5'd4;
        end
        1: begin
          pol_val = prlf_pkg::POLICY_FIFO;
          shift_val = 5'd0;  pcs_val = 4'd10; fiu_val = 5'd16;
        end
        2: begin
          pol_val = prlf_pkg::POLICY_LRU;
          shift_val = 5'd27; pcs_val = 4'd0;  fiu_val = 5'd1;
        end
        3: begin
          pol_val = prlf_pkg::POLICY_FIFO;
          shift_val = 5'($urandom_range(0, 27));
          pcs_val = 4'($urandom_range(0, 10));
          fiu_val = 5'($urandom_range(1, 16));
        end
        4: begin
          pol_val = prlf_pkg::POLICY_LRU;
          shift_val = 5'($urandom_range(0, 27));
          pcs_val = 4'($urandom_range(0, 15));
          fiu_val = 5'd0;
        end
        default: begin
          pol_val = prlf_pkg::policy_e'($urandom_range(0, 1));
          shift_val = 5'($urandom);
          pcs_val = 4'($urandom);
          fiu_val = 5'($urandom);
        end
      endcase
      wait_drained();
      write_reg(prlf_pkg::CFG_POLICY, {4'($urandom), pol_val});
      write_reg(prlf_pkg::CFG_PAGE_SHIFT, shift_val);
      write_reg(prlf_pkg::CFG_PAGE_COUNT_SHIFT, {1'($urandom), pcs_val});
      write_reg(prlf_pkg::CFG_FRAMES_IN_USE, fiu_val);
      cfg_we_i <= 1'b0;

      // working set a little larger than the active frames
      page_limit = (pcs_val >= 4'd10) ? MAX_PAGES : (1 << pcs_val);
      n_act = (fiu_val == 0) ? 1 : (fiu_val > MAX_FRAMES) ? MAX_FRAMES : fiu_val;
      pool.delete();
      repeat (n_act + $urandom_range(1, 6)) pool.push_back($urandom_range(0, page_limit - 1));
      off_mask = (64'd1 << shift_val) - 1;

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        sel = $urandom_range(0, 9);
        if (sel <= 6) begin
          page_no = pool[$urandom_range(0, pool.size() - 1)];
          addr = prlf_pkg::ADDR_W'((page_no << shift_val) |
                                   ({$urandom, $urandom} & off_mask));
        end else if (sel == 7) begin
          page_no = page_limit + $urandom_range(0, 1023);
          addr = prlf_pkg::ADDR_W'((page_no << shift_val) |
                                   ({$urandom, $urandom} & off_mask));
        end else begin
          addr = prlf_pkg::ADDR_W'($urandom);
        end
        gap = (k == PHASE_ITEMS - 1) ? -1 : next_gap();
        hold = (gap == 0);
        issue(addr, 1'b0, '0, hold);
        if (gap > 0) repeat (gap) @(posedge clk_i);
      end
    end

    // Drain and let any stray result show up
    wait_drained();
    repeat (40) @(posedge clk_i);
    if (expected_results.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/prlf_pkg.sv
sv/prlf_ram.sv
sv/prlf_ctrl.sv
sv/prlf_dp.sv
sv/page_replacement_lru_fifo.sv
verif/testbench.sv
